// ===== rtl/core/rsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Row segment detector package
// Shared constants and types of the row line-segment detector.
// ----------------------------------------------------------------------------
package rsd_pkg;

    localparam int MAX_ROW_WIDTH = 1024;
    localparam int MAX_WINDOW    = 31;

    localparam int PIXEL_W  = 8;
    localparam int WSIZE_W  = 5;
    localparam int COL_W    = 10;
    localparam int WIDTH_W  = 11;
    localparam int SEGNUM_W = 9;
    localparam int HALF_W   = WSIZE_W - 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_ROW_WIDTH - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESH_LEVEL = 2'd0,
        REG_WINDOW_SIZE  = 2'd1,
        REG_WIDTH_LO     = 2'd2,
        REG_WIDTH_HI     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] thresh_level;
        logic [WSIZE_W-1:0] window_size;
        logic [WIDTH_W-1:0] width_lo;
        logic [WIDTH_W-1:0] width_hi;
    } cfg_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               row_end;
    } pix_item_t;

    typedef struct packed {
        logic      valid;
        pix_item_t item;
    } pix_stage_t;

endpackage

// ===== rtl/core/rsd_if.sv =====
// ----------------------------------------------------------------------------
// Row segment detector channels
// Valid/ready channels for pixel items and segment result items.
// ----------------------------------------------------------------------------
interface rsd_pix_if;
    import rsd_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;
    logic               row_end;

    modport source (output valid, output pixel, output row_end, input ready);
    modport sink (input valid, input pixel, input row_end, output ready);
endinterface

interface rsd_seg_if;
    import rsd_pkg::*;

    logic                valid;
    logic                ready;
    logic [COL_W-1:0]    segment_start;
    logic [WIDTH_W-1:0]  segment_width;
    logic [COL_W-1:0]    segment_mid;
    logic                width_ok;
    logic [SEGNUM_W-1:0] segment_number;

    modport source (output valid, output segment_start, output segment_width,
                    output segment_mid, output width_ok, output segment_number,
                    input ready);
    modport sink (input valid, input segment_start, input segment_width,
                  input segment_mid, input width_ok, input segment_number,
                  output ready);
endinterface

// ===== rtl/core/rsd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Row segment detector configuration registers
// Holds the threshold, window size and line width limits.
// ----------------------------------------------------------------------------
module rsd_cfg_regs
    import rsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                REG_THRESH_LEVEL: cfg_next.thresh_level = cfg_data[PIXEL_W-1:0];
                REG_WINDOW_SIZE:  cfg_next.window_size  = cfg_data[WSIZE_W-1:0];
                REG_WIDTH_LO:     cfg_next.width_lo     = cfg_data[WIDTH_W-1:0];
                REG_WIDTH_HI:     cfg_next.width_hi     = cfg_data[WIDTH_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.thresh_level <= PIXEL_W'(128);
            cfg_reg.window_size  <= WSIZE_W'(5);
            cfg_reg.width_lo     <= WIDTH_W'(3);
            cfg_reg.width_hi     <= WIDTH_W'(30);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/rsd_input_stage.sv =====
// ----------------------------------------------------------------------------
// Row segment detector input stage
// Registers one pixel item and hands it on when the tracker can take it.
// ----------------------------------------------------------------------------
module rsd_input_stage
    import rsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rsd_pix_if.sink    pixels,
    input  logic       take,
    output pix_stage_t stage
);

    logic      valid_reg;
    logic      valid_next;
    pix_item_t item_reg;
    logic      accept;

    // The held item leaves in the same cycle a new one can come in.
    assign pixels.ready = !valid_reg || take;
    assign accept       = pixels.valid && pixels.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.pixel   <= pixels.pixel;
            item_reg.row_end <= pixels.row_end;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

// ===== rtl/core/rsd_run_tracker.sv =====
// ----------------------------------------------------------------------------
// Row segment detector run tracker
// Sliding threshold window, run measurement and the result register.
// ----------------------------------------------------------------------------
module rsd_run_tracker
    import rsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  pix_stage_t stage,
    output logic       take,
    rsd_seg_if.source  segments
);

    logic [MAX_WINDOW-1:0] win_reg, win_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic                  run_active_reg, run_active_next;
    logic [COL_W-1:0]      run_start_reg, run_start_next;
    logic [WIDTH_W-1:0]    run_width_reg, run_width_next;
    logic [SEGNUM_W-1:0]   segs_reg, segs_next;

    logic                  out_valid_reg, out_valid_next;
    logic [COL_W-1:0]      out_start_reg;
    logic [WIDTH_W-1:0]    out_width_reg;
    logic [COL_W-1:0]      out_mid_reg;
    logic                  out_ok_reg;
    logic [SEGNUM_W-1:0]   out_num_reg;

    logic                  proc;
    logic                  last;
    logic                  white;
    logic [HALF_W-1:0]     half;
    logic [WSIZE_W-1:0]    span;
    logic [MAX_WINDOW-1:0] shifted;
    logic [MAX_WINDOW-1:0] mask;
    logic                  active;
    logic                  open_run;
    logic [COL_W-1:0]      cur_start;
    logic [WIDTH_W-1:0]    cur_width;
    logic                  emit;

    assign take = !out_valid_reg || segments.ready;
    assign proc = stage.valid && take;

    always_comb
    begin
        last  = stage.item.row_end || (col_reg == LAST_COL);
        white = stage.item.pixel >= cfg.thresh_level;
        if (cfg.window_size == '0)
        begin
            half = '0;
        end
        else
        begin
            half = HALF_W'((cfg.window_size - WSIZE_W'(1)) >> 1);
        end
        span    = {half, 1'b0};
        shifted = {win_reg[MAX_WINDOW-2:0], white};
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            mask[i] = (WSIZE_W'(i) <= span);
        end
        // Column c-h is decided now; it needs h columns of margin on the left.
        active   = (col_reg >= COL_W'(span)) && ((shifted & mask) != '0);
        open_run = run_active_reg || active;
        if (run_active_reg)
        begin
            cur_start = run_start_reg;
            cur_width = run_width_reg + WIDTH_W'(active);
        end
        else
        begin
            cur_start = col_reg - COL_W'(half);
            cur_width = WIDTH_W'(active);
        end
        emit = open_run && (!active || last);
    end

    always_comb
    begin
        win_next        = win_reg;
        col_next        = col_reg;
        run_active_next = run_active_reg;
        run_start_next  = run_start_reg;
        run_width_next  = run_width_reg;
        segs_next       = segs_reg;
        if (proc)
        begin
            if (last)
            begin
                win_next        = '0;
                col_next        = '0;
                run_active_next = 1'b0;
                run_start_next  = '0;
                run_width_next  = '0;
                segs_next       = '0;
            end
            else
            begin
                win_next        = shifted;
                col_next        = col_reg + COL_W'(1);
                run_active_next = active;
                run_start_next  = cur_start;
                run_width_next  = cur_width;
                segs_next       = segs_reg + SEGNUM_W'(emit);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = proc && emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg        <= '0;
            col_reg        <= '0;
            run_active_reg <= 1'b0;
            run_start_reg  <= '0;
            run_width_reg  <= '0;
            segs_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            win_reg        <= win_next;
            col_reg        <= col_next;
            run_active_reg <= run_active_next;
            run_start_reg  <= run_start_next;
            run_width_reg  <= run_width_next;
            segs_reg       <= segs_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && emit)
        begin
            out_start_reg <= cur_start;
            out_width_reg <= cur_width;
            out_mid_reg   <= cur_start + COL_W'(cur_width >> 1);
            out_ok_reg    <= (cur_width >= cfg.width_lo)
                             && (cur_width <= cfg.width_hi);
            out_num_reg   <= segs_reg;
        end
    end

    assign segments.valid          = out_valid_reg;
    assign segments.segment_start  = out_start_reg;
    assign segments.segment_width  = out_width_reg;
    assign segments.segment_mid    = out_mid_reg;
    assign segments.width_ok       = out_ok_reg;
    assign segments.segment_number = out_num_reg;

    // A row's last pixel always leaves the tracker at column zero with no open run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (proc && last) |=> (col_reg == '0 && !run_active_reg))
        else $error("row end did not restart the row");

    // An open run always started at a column already passed.
    assert property (@(posedge clk) disable iff (!rst_n)
        run_active_reg |-> (col_reg > run_start_reg))
        else $error("open run starts beyond the current column");

    // A reported segment is never empty and its midpoint lies inside it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_width_reg != '0 && out_mid_reg >= out_start_reg))
        else $error("malformed segment result");

    // Results are only produced from a processed pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(proc))
        else $error("result appeared without a pixel");

endmodule

// ===== rtl/core/row_line_segment_detector.sv =====
// ----------------------------------------------------------------------------
// Row line-segment detector
// Finds runs of columns near bright pixels in an image row and reports
// each run's start, width, midpoint, width check and index in the row.
// ----------------------------------------------------------------------------
//  Channel    Direction  Item
//  pixels     in         pixel (8 b), row_end (1 b)
//  segments   out        segment_start, segment_width, segment_mid,
//                        width_ok, segment_number
//  cfg_*      in         register writes, index 0..3
//
//  One pixel item is taken every cycle while no result is stalled; each
//  item passes the input register and then the run tracker, which
//  registers its result in the output register of the segments channel.
//  The per-pixel window and run update is a single short stage.
//  A stalled result holds the tracker and the input register; the input
//  still takes an item in the cycle the waiting result is taken.
//  Reset clears the window, column count, run state and the result valid.
// ----------------------------------------------------------------------------
module row_line_segment_detector
    import rsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    rsd_pix_if.sink               pixels,
    rsd_seg_if.source             segments,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg;
    pix_stage_t stage;
    logic       take;

    rsd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rsd_input_stage u_input_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixels (pixels),
        .take   (take),
        .stage  (stage)
    );

    rsd_run_tracker u_run_tracker (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .stage    (stage),
        .take     (take),
        .segments (segments)
    );

endmodule

// ===== bench/row_line_segment_detector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row line-segment detector testbench
// Streams pixel rows through the detector under several register settings,
// with random idle cycles on both channels and one long output hold-off.
// Every segment item is compared field by field against an in-bench model
// of the window threshold and run tracking; a short directed table at reset
// settings carries hand-computed segments.
// ----------------------------------------------------------------------------
module row_line_segment_detector_tb;
    import rsd_pkg::*;

    localparam int CLK_HALF        = 2;
    localparam int RESET_CYCLES    = 5;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int RANDOM_ITEMS    = 1050;
    localparam int PHASE_ITEMS     = 60;
    localparam int NUM_FIXED       = 8;
    localparam int DRAIN_CYCLES    = 4;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic [COL_W-1:0]    seg_start;
        logic [WIDTH_W-1:0]  seg_width;
        logic [COL_W-1:0]    seg_mid;
        logic                seg_ok;
        logic [SEGNUM_W-1:0] seg_num;
    } segment_t;

    typedef enum logic [1:0] {
        FROM_MODEL,
        NO_SEGMENT,
        TYPED_SEGMENT
    } row_check_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               row_end;
        row_check_t         check;
        segment_t           want;
    } directed_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rsd_pix_if pix_ch();
    rsd_seg_if seg_ch();

    row_line_segment_detector i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pix_ch),
        .segments  (seg_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register shadow and row state of the segment model.
    cfg_t                model_cfg;
    logic [MAX_WINDOW-1:0] white_hist;
    logic [COL_W-1:0]    col_pos;
    logic                run_on;
    logic [COL_W-1:0]    run_first;
    logic [WIDTH_W-1:0]  run_len;
    logic [SEGNUM_W-1:0] seg_index;

    segment_t      expected_segments[$];
    directed_row_t directed_rows[$];

    int  cycle_count      = 0;
    int  items_sent       = 0;
    int  segments_checked = 0;
    int  error_count      = 0;
    int  settings_used    = 0;
    bit  sender_burst     = 1'b0;
    bit  hold_off_req     = 1'b0;

    int fix_thr  [NUM_FIXED] = '{128, 0, 255, 100, 60, 200, 90, 30};
    int fix_ws   [NUM_FIXED] = '{5, 1, 31, 0, 4, 31, 2, 7};
    int fix_minw [NUM_FIXED] = '{3, 0, 1024, 1, 2, 5, 0, 8};
    int fix_maxw [NUM_FIXED] = '{30, 1024, 0, 4, 10, 60, 0, 8};

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic segment_t make_segment(input int start, input int wid, input int mid,
                                              input int ok, input int num);
        segment_t s;
        s.seg_start = COL_W'(start);
        s.seg_width = WIDTH_W'(wid);
        s.seg_mid   = COL_W'(mid);
        s.seg_ok    = ok[0];
        s.seg_num   = SEGNUM_W'(num);
        return s;
    endfunction

    task automatic clear_row_state();
        white_hist = '0;
        col_pos    = '0;
        run_on     = 1'b0;
        run_first  = '0;
        run_len    = '0;
        seg_index  = '0;
    endtask

    // Column col_pos-half is decided when the pixel of col_pos arrives.
    task automatic track_pixel(input logic [PIXEL_W-1:0] px, input logic eol,
                               output logic found, output segment_t seg);
        logic        last;
        int          half;
        logic        act;
        logic [31:0] span;
        last = eol || (col_pos == LAST_COL);
        half = (model_cfg.window_size == 0) ? 0 : (int'(model_cfg.window_size) - 1) / 2;
        white_hist = {white_hist[MAX_WINDOW-2:0], (px >= model_cfg.thresh_level)};
        act = 1'b0;
        if (int'(col_pos) >= 2 * half)
        begin
            span = (32'd1 << (2 * half + 1)) - 32'd1;
            act  = |({1'b0, white_hist} & span);
        end
        found = 1'b0;
        seg   = '0;
        if (act)
        begin
            if (!run_on)
            begin
                run_on    = 1'b1;
                run_first = col_pos - COL_W'(half);
                run_len   = '0;
            end
            run_len = run_len + WIDTH_W'(1);
        end
        if (run_on && (!act || last))
        begin
            seg.seg_start = run_first;
            seg.seg_width = run_len;
            seg.seg_mid   = COL_W'(run_first + (run_len >> 1));
            seg.seg_ok    = (run_len >= model_cfg.width_lo) &&
                            (run_len <= model_cfg.width_hi);
            seg.seg_num   = seg_index;
            seg_index     = seg_index + SEGNUM_W'(1);
            run_on        = 1'b0;
            found         = 1'b1;
        end
        if (last)
            clear_row_state();
        else
            col_pos = col_pos + COL_W'(1);
    endtask

    // Called right after a rising edge; returns right after the edge that took the item.
    task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic eol,
                              input row_check_t check, input segment_t want);
        int       gap;
        logic     found;
        segment_t seg;
        gap = sender_burst ? 0 : pick_idle();
        if (gap > 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_ch.valid   <= 1'b1;
        pix_ch.pixel   <= px;
        pix_ch.row_end <= eol;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        track_pixel(px, eol, found, seg);
        case (check)
            FROM_MODEL:    if (found) expected_segments.insert(expected_segments.size(), seg);
            TYPED_SEGMENT: expected_segments.insert(expected_segments.size(), want);
            default:       ;
        endcase
        items_sent++;
    endtask

    // Bright stripes on a dark background, with the odd row of pure noise.
    task automatic send_random_row(input bit open_end, output int count);
        int                 len;
        int                 pick;
        int                 stripe_left;
        int                 gap_left;
        bit                 noisy;
        logic [PIXEL_W-1:0] px;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            len = $urandom_range(1, 5);
        else if (pick < 85)
            len = $urandom_range(6, 60);
        else
            len = $urandom_range(61, 200);
        noisy       = ($urandom_range(0, 9) == 0);
        stripe_left = 0;
        gap_left    = $urandom_range(0, 20);
        for (int i = 0; i < len; i++)
        begin
            if (noisy)
                px = PIXEL_W'($urandom_range(0, 255));
            else if (gap_left > 0)
            begin
                gap_left--;
                px = (model_cfg.thresh_level == 0) ? 8'd0 :
                     PIXEL_W'($urandom_range(0, int'(model_cfg.thresh_level) - 1));
            end
            else
            begin
                if (stripe_left == 0)
                    stripe_left = $urandom_range(1, 12);
                px = PIXEL_W'($urandom_range(int'(model_cfg.thresh_level), 255));
                stripe_left--;
                if (stripe_left == 0)
                    gap_left = $urandom_range(1, 40);
            end
            send_pixel(px, !open_end && (i == len - 1), FROM_MODEL, '0);
        end
        count = len;
    endtask

    // Lets the block run dry so that registers can be rewritten safely.
    task automatic wait_idle();
        pix_ch.valid <= 1'b0;
        while (expected_segments.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input int thr, input int ws, input int minw, input int maxw);
        cfg_write <= 1'b1;
        cfg_index <= REG_THRESH_LEVEL;
        cfg_data  <= CFG_DATA_W'(thr);
        @(posedge clk);
        cfg_index <= REG_WINDOW_SIZE;
        cfg_data  <= CFG_DATA_W'(ws);
        @(posedge clk);
        cfg_index <= REG_WIDTH_LO;
        cfg_data  <= CFG_DATA_W'(minw);
        @(posedge clk);
        cfg_index <= REG_WIDTH_HI;
        cfg_data  <= CFG_DATA_W'(maxw);
        @(posedge clk);
        cfg_write <= 1'b0;
        model_cfg.thresh_level = PIXEL_W'(thr);
        model_cfg.window_size  = WSIZE_W'(ws);
        model_cfg.width_lo     = WIDTH_W'(minw);
        model_cfg.width_hi     = WIDTH_W'(maxw);
        settings_used++;
    endtask

    task automatic add_row(input int px, input int eol, input row_check_t check,
                           input segment_t want);
        directed_row_t r;
        r.pixel   = PIXEL_W'(px);
        r.row_end = eol[0];
        r.check   = check;
        r.want    = want;
        directed_rows.insert(directed_rows.size(), r);
    endtask

    // Segment sink: checks every taken item, then picks the next ready value.
    initial
    begin : segment_sink
        int       stall_left;
        int       hold_left;
        bit       calm;
        segment_t got;
        segment_t want;
        stall_left   = 0;
        hold_left    = 0;
        calm         = 1'b0;
        seg_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (seg_ch.valid && seg_ch.ready)
            begin
                got = {seg_ch.segment_start, seg_ch.segment_width, seg_ch.segment_mid,
                       seg_ch.width_ok, seg_ch.segment_number};
                if (expected_segments.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("unexpected segment: start %0d width %0d mid %0d ok %0d num %0d",
                                 got.seg_start, got.seg_width, got.seg_mid, got.seg_ok,
                                 got.seg_num);
                end
                else
                begin
                    want = expected_segments.pop_front();
                    segments_checked++;
                    if (got.seg_start !== want.seg_start || got.seg_width !== want.seg_width ||
                        got.seg_mid !== want.seg_mid || got.seg_ok !== want.seg_ok ||
                        got.seg_num !== want.seg_num)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                        begin
                            $write("segment mismatch: expected %0d/%0d/%0d/%0d/%0d",
                                   want.seg_start, want.seg_width, want.seg_mid,
                                   want.seg_ok, want.seg_num);
                            $display(", got %0d/%0d/%0d/%0d/%0d (start/width/mid/ok/num)",
                                     got.seg_start, got.seg_width, got.seg_mid,
                                     got.seg_ok, got.seg_num);
                        end
                    end
                end
            end
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (cycle_count % 256 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (hold_left > 0)
            begin
                hold_left--;
                seg_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                seg_ch.ready <= 1'b0;
            end
            else
            begin
                seg_ch.ready <= 1'b1;
                if (!calm)
                    stall_left = pick_idle();
            end
        end
    end

    initial
    begin : main_flow
        int phase;
        int phase_items;
        int random_items;
        int n;
        int minw;
        rst_n          = 1'b0;
        pix_ch.valid   = 1'b0;
        pix_ch.pixel   = '0;
        pix_ch.row_end = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = REG_THRESH_LEVEL;
        cfg_data       = '0;

        model_cfg.thresh_level = 8'd128;
        model_cfg.window_size  = 5'd5;
        model_cfg.width_lo     = 11'd3;
        model_cfg.width_hi     = 11'd30;
        clear_row_state();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: threshold 128, half-width 2, widths 3..30.
        // One white pixel in mid-row lights five columns.
        for (int i = 0; i < 4; i++) add_row(0, 0, NO_SEGMENT, '0);
        add_row(255, 0, NO_SEGMENT, '0);
        for (int i = 0; i < 4; i++) add_row(0, 0, NO_SEGMENT, '0);
        add_row(0, 1, TYPED_SEGMENT, make_segment(2, 5, 4, 1, 0));
        // A white pixel at the left edge only reaches the first column that
        // can be active; 127 sits just under the threshold.
        add_row(128, 0, NO_SEGMENT, '0);
        for (int i = 0; i < 4; i++) add_row(0, 0, NO_SEGMENT, '0);
        add_row(0, 0, TYPED_SEGMENT, make_segment(2, 1, 2, 0, 0));
        for (int i = 0; i < 3; i++) add_row(0, 0, NO_SEGMENT, '0);
        add_row(127, 1, NO_SEGMENT, '0);
        // A row narrower than the window has no active column.
        add_row(255, 1, NO_SEGMENT, '0);
        // A run still open on the last pixel is closed by the row end.
        for (int i = 0; i < 4; i++) add_row(0, 0, NO_SEGMENT, '0);
        add_row(255, 0, NO_SEGMENT, '0);
        add_row(255, 1, TYPED_SEGMENT, make_segment(2, 2, 3, 0, 0));

        foreach (directed_rows[i])
            send_pixel(directed_rows[i].pixel, directed_rows[i].row_end,
                       directed_rows[i].check, directed_rows[i].want);
        wait_idle();

        // Random rows under fixed corner settings first, then random ones.
        // A phase may stop mid-row, so the next settings apply to an open row.
        phase        = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS || phase < NUM_FIXED)
        begin
            if (phase < NUM_FIXED)
                set_config(fix_thr[phase], fix_ws[phase], fix_minw[phase], fix_maxw[phase]);
            else
            begin
                minw = $urandom_range(0, 12);
                set_config($urandom_range(0, 255),
                           ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                       : $urandom_range(0, 9),
                           minw, minw + $urandom_range(0, 40));
            end
            sender_burst = ($urandom_range(0, 3) == 0);
            // The sink holds off for a long stretch while rows keep coming.
            if (phase == 1)
                hold_off_req = 1'b1;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                send_random_row(1'b0, n);
                phase_items += n;
            end
            if ($urandom_range(0, 1) == 1)
            begin
                send_random_row(1'b1, n);
                phase_items += n;
            end
            random_items += phase_items;
            wait_idle();
            phase++;
        end

        $display("%0d pixel items over %0d register settings, %0d segments checked",
                 items_sent, settings_used, segments_checked);
        $display("%0d errors", error_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
